// ===== design/utf8_length_and_slice_scanner_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 scanner assertion macros
// Concurrent assertion shorthands shared by the scanner's checking code.
// ----------------------------------------------------------------------------
`ifndef UTF8_LENGTH_AND_SLICE_SCANNER_ASSERT_SVH
`define UTF8_LENGTH_AND_SLICE_SCANNER_ASSERT_SVH

// Assertion on an explicit clock and synchronous active-high reset.
`define UTF8LS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define UTF8LS_ASSERT(label, prop, msg) \
   `UTF8LS_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== design/utf8ls_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 scanner package
// Shared widths, status codes, transfer structs and the lead byte decoder.
// ----------------------------------------------------------------------------
package utf8ls_pkg;

   localparam int MAX_BYTES = 4096;
   localparam int CNT_W     = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_END   = 2'd1;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BYTES);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_TOO_LONG = 2'd2,
      STATUS_RANGE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last;
   } in_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] char_count;
      status_type       status;
      logic [CNT_W-1:0] slice_offset;
      logic [CNT_W-1:0] slice_bytes;
   } scan_result_type;

   // Size of a code point from its lead byte, 0 for a byte that cannot lead.
   function automatic logic [2:0] lead_size(input logic [7:0] b);
      logic [2:0] size;
      if ((b >= 8'h80 && b <= 8'hC1) || b >= 8'hF5) begin
         size = 3'd0;
      end else if (b[7] == 1'b0) begin
         size = 3'd1;
      end else if ((b & 8'hE0) == 8'hC0) begin
         size = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         size = 3'd3;
      end else begin
         size = 3'd4;
      end
      return size;
   endfunction

endpackage

// ===== design/utf8ls_in_reg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 scanner input register
// Registers one byte transfer and hands it to the scan stage.
// ----------------------------------------------------------------------------
module utf8ls_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  utf8ls_pkg::in_item_type req_item,
   input  logic                  advance,
   output logic                  item_fire,
   output utf8ls_pkg::in_item_type item
);

   logic                    valid_ff;
   utf8ls_pkg::in_item_type item_ff;

   assign req_ready = !valid_ff || advance;
   assign item_fire = valid_ff && advance;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== design/utf8ls_scan.sv =====
// ----------------------------------------------------------------------------
// UTF-8 scanner core
// Holds the per-string counters and forms the result at the end of a string.
// ----------------------------------------------------------------------------
module utf8ls_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_fire,
   input  utf8ls_pkg::in_item_type            item,
   input  logic [utf8ls_pkg::CNT_W-1:0]       slice_start,
   input  logic [utf8ls_pkg::CNT_W-1:0]       slice_end,
   output logic                               res_valid,
   output utf8ls_pkg::scan_result_type        result
);

   localparam int W = utf8ls_pkg::CNT_W;

   logic [1:0]             skip_left_ff, skip_left_in;
   logic [W-1:0]           code_points_ff, code_points_in;
   logic [W-1:0]           byte_index_ff, byte_index_in;
   utf8ls_pkg::status_type error_code_ff, error_code_in;
   logic [W-1:0]           start_offset_ff, start_offset_in;
   logic [W-1:0]           end_offset_ff, end_offset_in;
   logic                   end_seen_ff, end_seen_in;
   logic                   draining_ff, draining_in;

   logic       done;
   logic [2:0] size;
   logic [W-1:0] stop;

   always_comb begin
      skip_left_in    = skip_left_ff;
      code_points_in  = code_points_ff;
      byte_index_in   = byte_index_ff;
      error_code_in   = error_code_ff;
      start_offset_in = start_offset_ff;
      end_offset_in   = end_offset_ff;
      end_seen_in     = end_seen_ff;
      draining_in     = draining_ff;
      done            = 1'b0;
      res_valid       = 1'b0;
      size            = utf8ls_pkg::lead_size(item.byte_value);
      stop            = '0;
      result          = '{char_count: '0, status: utf8ls_pkg::STATUS_OK,
                          slice_offset: '0, slice_bytes: '0};

      if (item_fire && draining_ff) begin
         // drop bytes after an early end, up to the flagged last one
         if (item.last) begin
            draining_in = 1'b0;
         end
      end else if (item_fire) begin
         done = item.last;
         if (skip_left_ff != 2'd0) begin
            skip_left_in = skip_left_ff - 2'd1;
            if (byte_index_ff < utf8ls_pkg::MAX_COUNT) begin
               byte_index_in = byte_index_ff + W'(1);
            end
         end else if (item.byte_value == 8'h00) begin
            done = 1'b1;
         end else if (byte_index_ff >= utf8ls_pkg::MAX_COUNT) begin
            error_code_in = utf8ls_pkg::STATUS_TOO_LONG;
            done          = 1'b1;
         end else if (size == 3'd0) begin
            error_code_in = utf8ls_pkg::STATUS_INVALID;
            done          = 1'b1;
         end else begin
            if (code_points_ff == slice_start) begin
               start_offset_in = byte_index_ff;
            end
            if (code_points_ff == slice_end) begin
               end_offset_in = byte_index_ff;
               end_seen_in   = 1'b1;
            end
            if (code_points_ff < utf8ls_pkg::MAX_COUNT) begin
               code_points_in = code_points_ff + W'(1);
            end
            byte_index_in = byte_index_ff + W'(1);
            skip_left_in  = 2'(size - 3'd1);
         end

         if (done) begin
            res_valid         = 1'b1;
            result.char_count = code_points_in;
            if (error_code_in != utf8ls_pkg::STATUS_OK) begin
               result.status = error_code_in;
            end else if (slice_start > code_points_in || slice_end > code_points_in ||
                         slice_start > slice_end) begin
               result.status = utf8ls_pkg::STATUS_RANGE;
            end else if (slice_start != slice_end) begin
               stop                = end_seen_in ? end_offset_in : byte_index_in;
               result.slice_offset = start_offset_in;
               result.slice_bytes  = (stop >= start_offset_in) ?
                                     stop - start_offset_in : '0;
            end
            // clear the run; wait for the last flag after an early end
            skip_left_in    = '0;
            code_points_in  = '0;
            byte_index_in   = '0;
            error_code_in   = utf8ls_pkg::STATUS_OK;
            start_offset_in = '0;
            end_offset_in   = '0;
            end_seen_in     = 1'b0;
            draining_in     = !item.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_left_ff    <= '0;
         code_points_ff  <= '0;
         byte_index_ff   <= '0;
         error_code_ff   <= utf8ls_pkg::STATUS_OK;
         start_offset_ff <= '0;
         end_offset_ff   <= '0;
         end_seen_ff     <= 1'b0;
         draining_ff     <= 1'b0;
      end else begin
         skip_left_ff    <= skip_left_in;
         code_points_ff  <= code_points_in;
         byte_index_ff   <= byte_index_in;
         error_code_ff   <= error_code_in;
         start_offset_ff <= start_offset_in;
         end_offset_ff   <= end_offset_in;
         end_seen_ff     <= end_seen_in;
         draining_ff     <= draining_in;
      end
   end

endmodule

// ===== design/utf8_length_and_slice_scanner.sv =====
// ----------------------------------------------------------------------------
// UTF-8 length and slice scanner
// Counts code points of a byte stream and locates a code point slice in it.
// ----------------------------------------------------------------------------
// Timing: the byte that ends a string passes the input register, then the
//   result register, before its result appears on rsp.
// Throughput: one byte per cycle, set by the single-pass scan stage; a result
//   waiting on rsp stalls the input register only while rsp_ready is low.
// Reset: synchronous, active high; clears the run state, the pipeline valid
//   bits and both slice registers to zero.
module utf8_length_and_slice_scanner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_byte_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [utf8ls_pkg::CNT_W-1:0]      rsp_char_count,
   output logic [1:0]                        rsp_status,
   output logic [utf8ls_pkg::CNT_W-1:0]      rsp_slice_offset,
   output logic [utf8ls_pkg::CNT_W-1:0]      rsp_slice_bytes,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [utf8ls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [utf8ls_pkg::CNT_W-1:0]      csr_data
);

   `include "utf8_length_and_slice_scanner_assert.svh"

   // Slice registers: the user must write them only while the block is idle; the block does not enforce it.
   logic [utf8ls_pkg::CNT_W-1:0] slice_start_ff;
   logic [utf8ls_pkg::CNT_W-1:0] slice_end_ff;

   // Result register: holds one finished result until its transfer.
   logic                        rsp_valid_ff;
   utf8ls_pkg::scan_result_type rsp_data_ff;

   logic                        out_free;
   logic                        item_fire;
   utf8ls_pkg::in_item_type     req_item;
   utf8ls_pkg::in_item_type     item;
   logic                        res_valid;
   utf8ls_pkg::scan_result_type result;

   // The scan stage advances whenever the result register can take a result,
   // so a byte that ends a string never overwrites one still waiting.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign req_item.byte_value = req_byte_value;
   assign req_item.last       = req_last;

   utf8ls_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .advance   (out_free),
      .item_fire (item_fire),
      .item      (item)
   );

   utf8ls_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .item_fire   (item_fire),
      .item        (item),
      .slice_start (slice_start_ff),
      .slice_end   (slice_end_ff),
      .res_valid   (res_valid),
      .result      (result)
   );

   // Configuration writes; indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_start_ff <= '0;
         slice_end_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            utf8ls_pkg::CSR_SLICE_START: slice_start_ff <= csr_data;
            utf8ls_pkg::CSR_SLICE_END:   slice_end_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Load a new result when free, otherwise hold until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_count   = rsp_data_ff.char_count;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_slice_offset = rsp_data_ff.slice_offset;
   assign rsp_slice_bytes  = rsp_data_ff.slice_bytes;

   // A fault or range status never carries slice fields.
   `UTF8LS_ASSERT(a_fault_no_slice, rsp_valid && rsp_status != utf8ls_pkg::STATUS_OK |-> rsp_slice_offset == '0 && rsp_slice_bytes == '0, "slice fields set on a non-ok result")
   // The scan stage never produces a result while a waiting one is stalled.
   `UTF8LS_ASSERT(a_no_overrun, rsp_valid && !rsp_ready |-> !res_valid, "result produced while result register is stalled")
   // The input side stalls only behind a stalled result with a byte held.
   `UTF8LS_ASSERT(a_stall_cause, !req_ready |-> rsp_valid && !rsp_ready, "input stalled without a stalled result")
   // A completed string leaves a result on rsp in the next cycle.
   `UTF8LS_ASSERT(a_result_lands, res_valid |=> rsp_valid, "result lost before the result register")

endmodule

// ===== tb/utf8_length_and_slice_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 length and slice scanner testbench
// Feeds whole string buffers byte by byte: a table of hand-picked strings
// first, then random buffers built mostly from well-formed code points with
// some noise, invalid leads, early NULs and truncation. A scan model inside
// the bench, or a row's fixed result, gives every string's expected result,
// and each rsp transfer is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module utf8_length_and_slice_scanner_tb;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 1950;
   localparam int QUIET_TAIL     = 350;
   localparam int PRESSURE_AT    = 600;
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_MAX       = 6;
   localparam int CASE_COUNT     = 23;

   // Indexes that select no register; written only to toggle the index bits.
   localparam logic [utf8ls_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [utf8ls_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // One directed string: slice window, a run of fill bytes, then up to six
   // tail bytes (first byte in the top octet). The last byte carries last.
   typedef struct packed {
      logic [utf8ls_pkg::CNT_W-1:0] win_start;
      logic [utf8ls_pkg::CNT_W-1:0] win_end;
      logic [7:0]                   fill;
      logic [utf8ls_pkg::CNT_W-1:0] fill_n;
      logic [2:0]                   tail_n;
      logic [8*TAIL_MAX-1:0]        tail;
      logic                         fixed;
      utf8ls_pkg::scan_result_type  want;
   } scan_case_type;

   localparam scan_case_type SCAN_CASES [CASE_COUNT] = '{
      // single ASCII byte, empty slice at the origin
      '{13'd0, 13'd0, 8'h00, 13'd0, 3'd1, 48'h41_00_00_00_00_00, 1'b1,
        '{13'd1, utf8ls_pkg::STATUS_OK, 13'd0, 13'd0}},
      // one-code-point slice
      '{13'd0, 13'd1, 8'h00, 13'd0, 3'd1, 48'h41_00_00_00_00_00, 1'b1,
        '{13'd1, utf8ls_pkg::STATUS_OK, 13'd0, 13'd1}},
      // slice end past the count
      '{13'd0, 13'd4, 8'h00, 13'd0, 3'd6, 48'h41_C3_A9_E2_82_AC, 1'b1,
        '{13'd3, utf8ls_pkg::STATUS_RANGE, 13'd0, 13'd0}},
      // slice reaching the end of a mixed-width string
      '{13'd1, 13'd3, 8'h00, 13'd0, 3'd6, 48'h41_C3_A9_E2_82_AC, 1'b1,
        '{13'd3, utf8ls_pkg::STATUS_OK, 13'd1, 13'd5}},
      // start above end
      '{13'd2, 13'd1, 8'h00, 13'd0, 3'd2, 48'h41_42_00_00_00_00, 1'b1,
        '{13'd2, utf8ls_pkg::STATUS_RANGE, 13'd0, 13'd0}},
      // stray continuation byte as lead, then a drained byte
      '{13'd0, 13'd0, 8'h00, 13'd0, 3'd3, 48'h41_80_42_00_00_00, 1'b1,
        '{13'd1, utf8ls_pkg::STATUS_INVALID, 13'd0, 13'd0}},
      // overlong two-byte lead
      '{13'd0, 13'd0, 8'h00, 13'd0, 3'd1, 48'hC1_00_00_00_00_00, 1'b1,
        '{13'd0, utf8ls_pkg::STATUS_INVALID, 13'd0, 13'd0}},
      // lowest out-of-range lead
      '{13'd0, 13'd0, 8'h00, 13'd0, 3'd2, 48'hF5_41_00_00_00_00, 1'b1,
        '{13'd0, utf8ls_pkg::STATUS_INVALID, 13'd0, 13'd0}},
      // all-ones byte
      '{13'd0, 13'd0, 8'h00, 13'd0, 3'd1, 48'hFF_00_00_00_00_00, 1'b1,
        '{13'd0, utf8ls_pkg::STATUS_INVALID, 13'd0, 13'd0}},
      // NUL ends the string early, rest drained up to last
      '{13'd0, 13'd2, 8'h00, 13'd0, 3'd5, 48'h41_42_00_43_44_00, 1'b1,
        '{13'd2, utf8ls_pkg::STATUS_OK, 13'd0, 13'd2}},
      // NUL in a continuation position is skipped
      '{13'd0, 13'd2, 8'h00, 13'd0, 3'd4, 48'hC3_00_41_00_00_00, 1'b0, '0},
      // truncated four-byte code point at last
      '{13'd0, 13'd1, 8'h00, 13'd0, 3'd3, 48'hF0_9F_98_00_00_00, 1'b0, '0},
      // highest valid lead
      '{13'd1, 13'd1, 8'h00, 13'd0, 3'd4, 48'hF4_8F_BF_BF_00_00, 1'b1,
        '{13'd1, utf8ls_pkg::STATUS_OK, 13'd0, 13'd0}},
      // highest ASCII, slice end out of range
      '{13'd1, 13'd2, 8'h00, 13'd0, 3'd1, 48'h7F_00_00_00_00_00, 1'b1,
        '{13'd1, utf8ls_pkg::STATUS_RANGE, 13'd0, 13'd0}},
      // all-ones window registers
      '{13'h1FFF, 13'h1FFF, 8'h00, 13'd0, 3'd1, 48'h41_00_00_00_00_00, 1'b1,
        '{13'd1, utf8ls_pkg::STATUS_RANGE, 13'd0, 13'd0}},
      // full-size string, empty slice at its very end
      '{13'd4096, 13'd4096, 8'h61, 13'd4096, 3'd0, 48'h0, 1'b1,
        '{13'd4096, utf8ls_pkg::STATUS_OK, 13'd0, 13'd0}},
      // full-size string, slice over all of it
      '{13'd0, 13'd4096, 8'h61, 13'd4096, 3'd0, 48'h0, 1'b1,
        '{13'd4096, utf8ls_pkg::STATUS_OK, 13'd0, 13'd4096}},
      // lead past the byte limit
      '{13'd0, 13'd0, 8'h61, 13'd4096, 3'd1, 48'h62_00_00_00_00_00, 1'b1,
        '{13'd4096, utf8ls_pkg::STATUS_TOO_LONG, 13'd0, 13'd0}},
      // byte limit wins over an invalid lead
      '{13'd0, 13'd0, 8'h61, 13'd4096, 3'd1, 48'h80_00_00_00_00_00, 1'b1,
        '{13'd4096, utf8ls_pkg::STATUS_TOO_LONG, 13'd0, 13'd0}},
      // NUL at the byte limit still ends cleanly
      '{13'd0, 13'd0, 8'h61, 13'd4096, 3'd2, 48'h00_41_00_00_00_00, 1'b1,
        '{13'd4096, utf8ls_pkg::STATUS_OK, 13'd0, 13'd0}},
      // byte counter saturates while skipping continuation bytes
      '{13'd4095, 13'd4096, 8'h61, 13'd4095, 3'd4, 48'hF0_80_80_80_00_00, 1'b0, '0},
      // lone NUL
      '{13'd0, 13'd0, 8'h00, 13'd0, 3'd1, 48'h00_00_00_00_00_00, 1'b1,
        '{13'd0, utf8ls_pkg::STATUS_OK, 13'd0, 13'd0}},
      // mixed widths, slice from the second code point to the end
      '{13'd1, 13'd3, 8'h00, 13'd0, 3'd6, 48'hE2_82_AC_41_DF_BF, 1'b0, '0}
   };

   logic                             clock          = 1'b0;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_byte_value = 8'h00;
   logic                             req_last       = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready      = 1'b0;
   logic [utf8ls_pkg::CNT_W-1:0]     rsp_char_count;
   logic [1:0]                       rsp_status;
   logic [utf8ls_pkg::CNT_W-1:0]     rsp_slice_offset;
   logic [utf8ls_pkg::CNT_W-1:0]     rsp_slice_bytes;
   logic                             csr_valid      = 1'b0;
   logic                             csr_ready;
   logic [utf8ls_pkg::CSR_IDX_W-1:0] csr_index      = utf8ls_pkg::CSR_SLICE_START;
   logic [utf8ls_pkg::CNT_W-1:0]     csr_data       = '0;

   utf8_length_and_slice_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_value   (req_byte_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_count   (rsp_char_count),
      .rsp_status       (rsp_status),
      .rsp_slice_offset (rsp_slice_offset),
      .rsp_slice_bytes  (rsp_slice_bytes),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Scan model: window registers and the per-string scan state.
   // ------------------------------------------------------------------------
   logic [utf8ls_pkg::CNT_W-1:0] win_start = '0;
   logic [utf8ls_pkg::CNT_W-1:0] win_end   = '0;

   logic [1:0]                   cont_left     = '0;
   logic [utf8ls_pkg::CNT_W-1:0] points        = '0;
   logic [utf8ls_pkg::CNT_W-1:0] pos           = '0;
   utf8ls_pkg::status_type       fault         = utf8ls_pkg::STATUS_OK;
   logic [utf8ls_pkg::CNT_W-1:0] win_start_pos = '0;
   logic [utf8ls_pkg::CNT_W-1:0] win_end_pos   = '0;
   logic                         win_end_hit   = 1'b0;
   logic                         draining      = 1'b0;

   utf8ls_pkg::scan_result_type  expected_scans [$];
   utf8ls_pkg::scan_result_type  fixed_want;
   bit                           use_fixed = 1'b0;
   int                           mismatches = 0;

   bit               idle_on   = 1'b0;
   bit               hold_rsp  = 1'b0;
   logic [7:0]       text_q [$];

   function automatic logic [2:0] code_point_len(input logic [7:0] b);
      logic [2:0] len;
      if (b < 8'h80)      len = 3'd1;
      else if (b < 8'hC2) len = 3'd0;
      else if (b < 8'hE0) len = 3'd2;
      else if (b < 8'hF0) len = 3'd3;
      else if (b < 8'hF5) len = 3'd4;
      else                len = 3'd0;
      return len;
   endfunction

   task automatic clear_scan();
      cont_left     = '0;
      points        = '0;
      pos           = '0;
      fault         = utf8ls_pkg::STATUS_OK;
      win_start_pos = '0;
      win_end_pos   = '0;
      win_end_hit   = 1'b0;
      draining      = 1'b0;
   endtask

   // Advance the scan by one byte; fire is set when the string's result is due.
   task automatic scan_byte(input logic [7:0] b, input logic fin,
                            output bit fire, output utf8ls_pkg::scan_result_type res);
      logic [2:0]                   len;
      logic [utf8ls_pkg::CNT_W-1:0] stop_pos;
      bit                           done;
      fire = 1'b0;
      res  = '0;
      done = fin;
      if (draining) begin
         // string already reported: drop bytes until the buffer's last one
         if (fin) clear_scan();
      end else begin
         if (cont_left != 0) begin
            cont_left = cont_left - 2'd1;
            if (pos < utf8ls_pkg::MAX_COUNT) pos = pos + 1'b1;
         end else if (b == 8'h00) begin
            done = 1'b1;
         end else if (pos >= utf8ls_pkg::MAX_COUNT) begin
            fault = utf8ls_pkg::STATUS_TOO_LONG;
            done  = 1'b1;
         end else begin
            len = code_point_len(b);
            if (len == 3'd0) begin
               fault = utf8ls_pkg::STATUS_INVALID;
               done  = 1'b1;
            end else begin
               if (points == win_start) win_start_pos = pos;
               if (points == win_end) begin
                  win_end_pos = pos;
                  win_end_hit = 1'b1;
               end
               if (points < utf8ls_pkg::MAX_COUNT) points = points + 1'b1;
               if (pos < utf8ls_pkg::MAX_COUNT) pos = pos + 1'b1;
               cont_left = 2'(len - 3'd1);
            end
         end
         if (done) begin
            fire = 1'b1;
            res.char_count = points;
            if (fault != utf8ls_pkg::STATUS_OK) begin
               res.status = fault;
            end else if (win_start > points || win_end > points || win_start > win_end) begin
               res.status = utf8ls_pkg::STATUS_RANGE;
            end else begin
               res.status = utf8ls_pkg::STATUS_OK;
               if (win_start != win_end) begin
                  stop_pos = win_end_hit ? win_end_pos : pos;
                  res.slice_offset = win_start_pos;
                  res.slice_bytes  = (stop_pos >= win_start_pos) ? stop_pos - win_start_pos
                                                                 : '0;
               end
            end
            clear_scan();
            if (!fin) draining = 1'b1;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Watch all three channels at the clock edge: register writes update the
   // model's window, byte transfers advance the scan, and rsp transfers are
   // checked against the oldest expected result. Inputs go first so that an
   // expectation formed at this edge is already queued.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : track_and_check
      bit                          fire;
      utf8ls_pkg::scan_result_type res;
      utf8ls_pkg::scan_result_type want;
      if (reset) begin
         clear_scan();
         win_start = '0;
         win_end   = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == utf8ls_pkg::CSR_SLICE_START)    win_start = csr_data;
            else if (csr_index == utf8ls_pkg::CSR_SLICE_END) win_end   = csr_data;
         end
         if (req_valid && req_ready) begin
            scan_byte(req_byte_value, req_last, fire, res);
            if (fire) expected_scans.push_back(use_fixed ? fixed_want : res);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_scans.size() == 0) begin
               $error("unexpected result: char_count %0d status %0d offset %0d bytes %0d",
                      rsp_char_count, rsp_status, rsp_slice_offset, rsp_slice_bytes);
               mismatches++;
            end else begin
               want = expected_scans.pop_front();
               if (rsp_char_count !== want.char_count) begin
                  $error("char_count mismatch: expected %0d, actual %0d",
                         want.char_count, rsp_char_count);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_slice_offset !== want.slice_offset) begin
                  $error("slice_offset mismatch: expected %0d, actual %0d",
                         want.slice_offset, rsp_slice_offset);
                  mismatches++;
               end
               if (rsp_slice_bytes !== want.slice_bytes) begin
                  $error("slice_bytes mismatch: expected %0d, actual %0d",
                         want.slice_bytes, rsp_slice_bytes);
                  mismatches++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: a long hold-off when requested, otherwise random stall
   // bursts while idling is on, and always ready when off.
   // ------------------------------------------------------------------------
   int stall_left = 0;
   int hold_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_rsp) begin
         // hold off long enough for the block to back up into req
         rsp_ready <= 1'b0;
         if (hold_count == HOLD_CYCLES - 1) begin
            hold_count = 0;
            hold_rsp   = 1'b0;
         end else begin
            hold_count++;
         end
      end else if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // End the run when no transfer of any kind happens for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("utf8_length_and_slice_scanner test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Offer one byte, with an occasional gap first, and hold it until transfer.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_last       <= fin;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send the buffer in text_q; its final byte carries last.
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
   endtask

   // Write one register; keep csr_valid up when another write follows.
   task automatic write_reg(input logic [utf8ls_pkg::CSR_IDX_W-1:0] idx,
                            input logic [utf8ls_pkg::CNT_W-1:0] data,
                            input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (!more) csr_valid <= 1'b0;
   endtask

   // Drop req, let the model take in the byte transferred at this edge, and
   // wait until every string has reported, then let the bytes drained behind
   // the last result clear the pipeline.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   function automatic logic [utf8ls_pkg::CNT_W-1:0] edge_value();
      int pick;
      pick = $urandom_range(0, 2);
      return (pick == 0) ? 13'd0 : (pick == 1) ? utf8ls_pkg::MAX_COUNT : 13'h1FFF;
   endfunction

   // Build a random buffer: mostly well-formed code points, some with an
   // invalid lead spliced in, some ended by NUL plus junk or cut short, and
   // a share of raw noise.
   task automatic make_text(input int max_points);
      int         kind;
      int         n;
      int         bad_at;
      int         ending;
      logic [2:0] len;
      logic [2:0] last_len;
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         n        = $urandom_range(0, max_points);
         bad_at   = (kind >= 70) ? $urandom_range(0, n) : -1;
         last_len = 3'd1;
         for (int i = 0; i <= n; i++) begin
            if (i == bad_at) begin
               text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                                     : 8'($urandom_range(8'hF5, 8'hFF)));
            end
            if (i < n) begin
               len = 3'($urandom_range(1, 4));
               case (len)
                  3'd1:    text_q.push_back(8'($urandom_range(8'h01, 8'h7F)));
                  3'd2:    text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                  3'd3:    text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                  default: text_q.push_back(8'($urandom_range(8'hF0, 8'hF4)));
               endcase
               for (int j = 1; j < len; j++) text_q.push_back(cont_byte());
               last_len = len;
            end
         end
         ending = $urandom_range(0, 3);
         if (ending == 0) begin
            // early NUL, then bytes the block must drain silently
            text_q.push_back(8'h00);
            repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
         end else if (ending == 1 && n > 0 && last_len > 3'd1) begin
            // cut the final code point short
            repeat ($urandom_range(1, last_len - 1)) void'(text_q.pop_back());
         end
      end
      if (text_q.size() == 0) text_q.push_back(8'h00);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      scan_case_type                row;
      int                           random_items;
      int                           mode;
      int                           buffers;
      int                           max_points;
      bit                           pressed;
      bit                           pressure;
      logic [utf8ls_pkg::CNT_W-1:0] s_val;
      logic [utf8ls_pkg::CNT_W-1:0] e_val;

      random_items = 0;
      pressed      = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed strings, one per table row, each under its own window.
      idle_on = 1'b1;
      for (int r = 0; r < CASE_COUNT; r++) begin
         row = SCAN_CASES[r];
         wait_idle();
         write_reg(utf8ls_pkg::CSR_SLICE_START, row.win_start, 1'b1);
         write_reg(utf8ls_pkg::CSR_SLICE_END, row.win_end, 1'b0);
         use_fixed  = row.fixed;
         fixed_want = row.want;
         text_q.delete();
         for (int i = 0; i < row.fill_n; i++) text_q.push_back(row.fill);
         for (int k = 0; k < row.tail_n; k++) begin
            text_q.push_back(row.tail[8*TAIL_MAX-1-8*k -: 8]);
         end
         send_text();
      end

      // Random phases: a fresh window per phase, then a few buffers.
      wait_idle();
      use_fixed = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         mode = $urandom_range(0, 9);
         if (mode == 0) begin
            s_val = 13'($urandom_range(0, 13'h1FFF));
            e_val = 13'($urandom_range(0, 13'h1FFF));
         end else if (mode == 1) begin
            s_val = edge_value();
            e_val = edge_value();
         end else if (mode == 2) begin
            s_val = 13'($urandom_range(0, 6));
            e_val = 13'($urandom_range(0, 6));
         end else begin
            s_val = 13'($urandom_range(0, 6));
            e_val = s_val + 13'($urandom_range(0, 6));
         end
         if ($urandom_range(0, 5) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                      13'($urandom_range(0, 13'h1FFF)), 1'b1);
         end
         if ($urandom_range(0, 1) == 0) begin
            write_reg(utf8ls_pkg::CSR_SLICE_START, s_val, 1'b1);
            write_reg(utf8ls_pkg::CSR_SLICE_END, e_val, 1'b0);
         end else begin
            write_reg(utf8ls_pkg::CSR_SLICE_END, e_val, 1'b1);
            write_reg(utf8ls_pkg::CSR_SLICE_START, s_val, 1'b0);
         end

         // Back-to-back short strings against a stalled receiver, once.
         pressure = (random_items >= PRESSURE_AT) && !pressed;
         if (pressure) begin
            pressed    = 1'b1;
            idle_on    = 1'b0;
            hold_rsp   = 1'b1;
            buffers    = 12;
            max_points = 1;
         end else begin
            idle_on    = (random_items < RANDOM_ITEMS - QUIET_TAIL) &&
                         ($urandom_range(0, 3) != 0);
            buffers    = $urandom_range(1, 6);
            max_points = 20;
         end

         repeat (buffers) begin
            make_text(max_points);
            send_text();
            random_items += text_q.size();
         end
      end

      // Drain: every string must report, then allow for stray late results.
      wait_idle();
      if (mismatches == 0) begin
         $display("utf8_length_and_slice_scanner test passed");
      end else begin
         $display("utf8_length_and_slice_scanner test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/utf8ls_pkg.sv
design/utf8ls_in_reg.sv
design/utf8ls_scan.sv
design/utf8_length_and_slice_scanner.sv
tb/utf8_length_and_slice_scanner_tb.sv
